@@ hw/rtl/lcdseq_pkg.sv @@
// Shared types, constants and microcode word layout for the LCD nibble sequencer.
package lcdseq_pkg;

   localparam int PC_W = 6;

   localparam logic [2:0] KIND_INIT  = 3'd0;
   localparam logic [2:0] KIND_CMD   = 3'd1;
   localparam logic [2:0] KIND_CHAR  = 3'd2;
   localparam logic [2:0] KIND_ADDR  = 3'd3;
   localparam logic [2:0] KIND_CLEAR = 3'd4;

   localparam logic [1:0] CSR_ENABLE_PULSE = 2'd0;
   localparam logic [1:0] CSR_SETTLE       = 2'd1;
   localparam logic [1:0] CSR_WAKE_WAIT    = 2'd2;

   localparam logic [15:0] ENABLE_PULSE_RST = 16'd20;
   localparam logic [15:0] SETTLE_RST       = 16'd2000;
   localparam logic [15:0] WAKE_WAIT_RST    = 16'd5000;

   localparam logic [7:0] ROW1_LIMIT  = 8'h0F;
   localparam logic [7:0] ROW2_OFFSET = 8'h30;
   localparam logic [7:0] DDRAM_CMD   = 8'h80;
   localparam logic [7:0] CLEAR_CMD   = 8'h01;

   // nibble source
   localparam logic [1:0] NIB_CONST = 2'd0;
   localparam logic [1:0] NIB_HI    = 2'd1;
   localparam logic [1:0] NIB_LO    = 2'd2;

   // hold time source
   localparam logic [1:0] HOLD_PULSE = 2'd0;
   localparam logic [1:0] HOLD_SETTLE = 2'd1;
   localparam logic [1:0] HOLD_WAKE  = 2'd2;
   localparam logic [1:0] HOLD_ZERO  = 2'd3;

   // sequencing op
   localparam logic [1:0] OP_NEXT   = 2'd0;
   localparam logic [1:0] OP_DONE   = 2'd1;
   localparam logic [1:0] OP_BRANCH = 2'd2;

   // tail taken after a byte
   localparam logic [1:0] TAIL_NONE = 2'd0;
   localparam logic [1:0] TAIL_DROP = 2'd1;
   localparam logic [1:0] TAIL_WAIT = 2'd2;

   localparam logic [PC_W-1:0] PC_INIT      = 6'd0;
   localparam logic [PC_W-1:0] PC_BYTE      = 6'd33;
   localparam logic [PC_W-1:0] PC_TAIL_DROP = 6'd37;
   localparam logic [PC_W-1:0] PC_TAIL_WAIT = 6'd38;
   localparam logic [PC_W-1:0] PC_LAST      = 6'd38;

   typedef struct packed {
      logic [1:0] nib_sel;
      logic [3:0] nib_const;
      logic       rs_use;
      logic       en;
      logic [1:0] hold_sel;
      logic [1:0] op;
   } ucode_type;

   function automatic ucode_type uc(logic [1:0] nib_sel, logic [3:0] nib_const,
                                    logic rs_use, logic en, logic [1:0] hold_sel,
                                    logic [1:0] op);
      ucode_type w;
      w.nib_sel   = nib_sel;
      w.nib_const = nib_const;
      w.rs_use    = rs_use;
      w.en        = en;
      w.hold_sel  = hold_sel;
      w.op        = op;
      return w;
   endfunction

endpackage

@@ hw/rtl/lcdseq_ucode_rom.sv @@
// Microcode store: one control word per pin event of each run.
module lcdseq_ucode_rom
   import lcdseq_pkg::*;
(
   input  logic [PC_W-1:0] addr,
   output ucode_type       word
);

   always_comb begin
      unique case (addr)
         // power-up wait and wake nibbles
         6'd0:  word = uc(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_SETTLE, OP_NEXT);
         6'd1:  word = uc(NIB_CONST, 4'h3, 1'b0, 1'b1, HOLD_PULSE,  OP_NEXT);
         6'd2:  word = uc(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_PULSE,  OP_NEXT);
         6'd3:  word = uc(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_WAKE,   OP_NEXT);
         6'd4:  word = uc(NIB_CONST, 4'h3, 1'b0, 1'b1, HOLD_PULSE,  OP_NEXT);
         6'd5:  word = uc(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_PULSE,  OP_NEXT);
         6'd6:  word = uc(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_SETTLE, OP_NEXT);
         6'd7:  word = uc(NIB_CONST, 4'h3, 1'b0, 1'b1, HOLD_PULSE,  OP_NEXT);
         6'd8:  word = uc(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_PULSE,  OP_NEXT);
         6'd9:  word = uc(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_SETTLE, OP_NEXT);
         6'd10: word = uc(NIB_CONST, 4'h2, 1'b0, 1'b1, HOLD_PULSE,  OP_NEXT);
         6'd11: word = uc(NIB_CONST, 4'h2, 1'b0, 1'b0, HOLD_PULSE,  OP_NEXT);
         6'd12: word = uc(NIB_CONST, 4'h2, 1'b0, 1'b0, HOLD_SETTLE, OP_NEXT);
         // function set 0x28
         6'd13: word = uc(NIB_CONST, 4'h2, 1'b0, 1'b1, HOLD_PULSE,  OP_NEXT);
         6'd14: word = uc(NIB_CONST, 4'h2, 1'b0, 1'b0, HOLD_PULSE,  OP_NEXT);
         6'd15: word = uc(NIB_CONST, 4'h8, 1'b0, 1'b1, HOLD_PULSE,  OP_NEXT);
         6'd16: word = uc(NIB_CONST, 4'h8, 1'b0, 1'b0, HOLD_PULSE,  OP_NEXT);
         6'd17: word = uc(NIB_CONST, 4'h8, 1'b0, 1'b0, HOLD_SETTLE, OP_NEXT);
         // display on 0x0C
         6'd18: word = uc(NIB_CONST, 4'h0, 1'b0, 1'b1, HOLD_PULSE,  OP_NEXT);
         6'd19: word = uc(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_PULSE,  OP_NEXT);
         6'd20: word = uc(NIB_CONST, 4'hC, 1'b0, 1'b1, HOLD_PULSE,  OP_NEXT);
         6'd21: word = uc(NIB_CONST, 4'hC, 1'b0, 1'b0, HOLD_PULSE,  OP_NEXT);
         6'd22: word = uc(NIB_CONST, 4'hC, 1'b0, 1'b0, HOLD_SETTLE, OP_NEXT);
         // clear 0x01
         6'd23: word = uc(NIB_CONST, 4'h0, 1'b0, 1'b1, HOLD_PULSE,  OP_NEXT);
         6'd24: word = uc(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_PULSE,  OP_NEXT);
         6'd25: word = uc(NIB_CONST, 4'h1, 1'b0, 1'b1, HOLD_PULSE,  OP_NEXT);
         6'd26: word = uc(NIB_CONST, 4'h1, 1'b0, 1'b0, HOLD_PULSE,  OP_NEXT);
         6'd27: word = uc(NIB_CONST, 4'h1, 1'b0, 1'b0, HOLD_SETTLE, OP_NEXT);
         // entry mode 0x06
         6'd28: word = uc(NIB_CONST, 4'h0, 1'b0, 1'b1, HOLD_PULSE,  OP_NEXT);
         6'd29: word = uc(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_PULSE,  OP_NEXT);
         6'd30: word = uc(NIB_CONST, 4'h6, 1'b0, 1'b1, HOLD_PULSE,  OP_NEXT);
         6'd31: word = uc(NIB_CONST, 4'h6, 1'b0, 1'b0, HOLD_PULSE,  OP_NEXT);
         6'd32: word = uc(NIB_CONST, 4'h6, 1'b0, 1'b0, HOLD_SETTLE, OP_DONE);
         // generic byte from the byte register
         6'd33: word = uc(NIB_HI,    4'h0, 1'b1, 1'b1, HOLD_PULSE,  OP_NEXT);
         6'd34: word = uc(NIB_HI,    4'h0, 1'b1, 1'b0, HOLD_PULSE,  OP_NEXT);
         6'd35: word = uc(NIB_LO,    4'h0, 1'b1, 1'b1, HOLD_PULSE,  OP_NEXT);
         6'd36: word = uc(NIB_LO,    4'h0, 1'b1, 1'b0, HOLD_PULSE,  OP_BRANCH);
         // tails
         6'd37: word = uc(NIB_LO,    4'h0, 1'b0, 1'b0, HOLD_ZERO,   OP_DONE);
         6'd38: word = uc(NIB_LO,    4'h0, 1'b0, 1'b0, HOLD_SETTLE, OP_DONE);
         default: word = uc(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_ZERO, OP_DONE);
      endcase
   end

endmodule

@@ hw/rtl/char_lcd_nibble_sequencer.sv @@
// Top level: 4-bit character LCD driver expanding requests into pin events.
//
// Request channel (req_valid/req_stall, req_kind, req_value): init, command
// byte, character, cursor address or clear. Kinds 5..7 are taken and dropped.
// Result channel (rsp_valid/rsp_stall): one pin event per transfer with the
// data nibble, RS, E, hold time in microseconds and a last flag on the final
// event of each run.
// A request is taken only while no run is in progress. Once it is taken the
// busy register is set, and the first event is then registered into the output
// register once that register is free; after that one event is produced per
// cycle while the receiver does not stall. A run holds 33 events for init, 4 for
// command and address, 5 for character and clear. The run rate is set by the
// microcode step counter, which moves one control word per issued event. A
// stalled event holds in the output register and the step counter waits. The
// next request is taken as soon as the last event sits in the output register.
// Reset (synchronous, active high) ends any run, empties the output and
// loads the timing registers with 20, 2000 and 5000 microseconds.
module char_lcd_nibble_sequencer
   import lcdseq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_data_nibble,
   output logic        rsp_reg_select,
   output logic        rsp_enable,
   output logic [15:0] rsp_hold_us,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0]     pulse_ff, pulse_in;
   logic [15:0]     settle_ff, settle_in;
   logic [15:0]     wake_ff, wake_in;
   logic            busy_ff, busy_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic [7:0]      byte_ff, byte_in;
   logic            rs_ff, rs_in;
   logic [1:0]      tail_ff, tail_in;
   logic            vld_ff, vld_in;
   logic [3:0]      nib_ff, nib_in;
   logic            rsel_ff, rsel_in;
   logic            en_ff, en_in;
   logic [15:0]     hold_ff, hold_in;
   logic            last_ff, last_in;

   ucode_type       uword;
   logic            req_take;
   logic            known;
   logic            step;
   logic [7:0]      addr_adj;

   lcdseq_ucode_rom u_rom (
      .addr (pc_ff),
      .word (uword)
   );

   assign req_stall = busy_ff;
   assign req_take  = req_valid && !busy_ff;
   assign known     = (req_kind <= KIND_CLEAR);
   assign step      = busy_ff && (!vld_ff || !rsp_stall);
   assign addr_adj  = (req_value > ROW1_LIMIT) ? req_value + ROW2_OFFSET : req_value;

   always_comb begin
      pulse_in  = pulse_ff;
      settle_in = settle_ff;
      wake_in   = wake_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ENABLE_PULSE: pulse_in  = csr_wdata;
            CSR_SETTLE:       settle_in = csr_wdata;
            CSR_WAKE_WAIT:    wake_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      byte_in = byte_ff;
      rs_in   = rs_ff;
      tail_in = tail_ff;
      if (req_take) begin
         byte_in = req_value;
         rs_in   = 1'b0;
         tail_in = TAIL_NONE;
         case (req_kind)
            KIND_CHAR: begin
               rs_in   = 1'b1;
               tail_in = TAIL_DROP;
            end
            KIND_ADDR:  byte_in = DDRAM_CMD | addr_adj;
            KIND_CLEAR: begin
               byte_in = CLEAR_CMD;
               tail_in = TAIL_WAIT;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (uword.nib_sel)
         NIB_HI:  nib_in = byte_ff[7:4];
         NIB_LO:  nib_in = byte_ff[3:0];
         default: nib_in = uword.nib_const;
      endcase
      unique case (uword.hold_sel)
         HOLD_PULSE:  hold_in = pulse_ff;
         HOLD_SETTLE: hold_in = settle_ff;
         HOLD_WAKE:   hold_in = wake_ff;
         default:     hold_in = 16'd0;
      endcase
      rsel_in = uword.rs_use && rs_ff;
      en_in   = uword.en;
      last_in = (uword.op == OP_DONE) || ((uword.op == OP_BRANCH) && (tail_ff == TAIL_NONE));
   end

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (req_take) begin
         pc_in   = (req_kind == KIND_INIT) ? PC_INIT : PC_BYTE;
         busy_in = known;
      end else if (step) begin
         busy_in = !last_in;
         unique case (uword.op)
            OP_BRANCH: pc_in = (tail_ff == TAIL_DROP) ? PC_TAIL_DROP : PC_TAIL_WAIT;
            OP_NEXT:   pc_in = pc_ff + 1'b1;
            default:   pc_in = pc_ff;
         endcase
      end
      vld_in = step || (vld_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff  <= ENABLE_PULSE_RST;
         settle_ff <= SETTLE_RST;
         wake_ff   <= WAKE_WAIT_RST;
         busy_ff   <= 1'b0;
         vld_ff    <= 1'b0;
         pc_ff     <= PC_INIT;
      end else begin
         pulse_ff  <= pulse_in;
         settle_ff <= settle_in;
         wake_ff   <= wake_in;
         busy_ff   <= busy_in;
         vld_ff    <= vld_in;
         pc_ff     <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      rs_ff   <= rs_in;
      tail_ff <= tail_in;
      if (step) begin
         nib_ff  <= nib_in;
         rsel_ff <= rsel_in;
         en_ff   <= en_in;
         hold_ff <= hold_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid       = vld_ff;
   assign rsp_data_nibble = nib_ff;
   assign rsp_reg_select  = rsel_ff;
   assign rsp_enable      = en_ff;
   assign rsp_hold_us     = hold_ff;
   assign rsp_last        = last_ff;

`ifndef SYNTHESIS
   a_busy_until_last: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && !last_ff) |-> busy_ff)
      else $error("non-final event pending while sequencer idle");

   a_entry_point: assert property (@(posedge clock) disable iff (reset)
      (req_take && known) |=> (busy_ff && ((pc_ff == PC_INIT) || (pc_ff == PC_BYTE))))
      else $error("run did not start at a program entry");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pc_ff <= PC_LAST))
      else $error("step counter left the program");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && rsp_stall) |=> (vld_ff && $stable(hold_ff) && $stable(last_ff)))
      else $error("stalled event changed");
`endif

endmodule
